// File: rtl/dbtw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer package
// Shared sizes, command codes, register indexes and control structs for the
// depth buffer test-and-write block.
// ----------------------------------------------------------------------------
package dbtw_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int DEPTH_BITS = 32;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int COORD_W    = 9;
    localparam int SIZE_W     = 10;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
    localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(512);

    // Item commands.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TEST  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted request
        logic finish;   // commit the result and any store write
        logic clear;    // write one clear entry and advance the sweep
    } dbtw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;   // captured request is a clear
        logic clr_last;   // sweep address is at the last entry
        logic out_free;   // result register can take a new result
    } dbtw_status_t;

    // Register value 0 acts as 1, values above the limit act as the limit.
    function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] r,
                                                      input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] s;
        begin
            s = r;
            if (r == '0)
            begin
                s = SIZE_W'(1);
            end
            else if (r > lim)
            begin
                s = lim;
            end
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/dbtw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer request channel
// Valid/ready channel carrying one depth buffer request.
// ----------------------------------------------------------------------------
interface dbtw_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [1:0]                                command;
    logic [dbtw_pkg::COORD_W-1:0]              pixel_x;
    logic [dbtw_pkg::COORD_W-1:0]              pixel_y;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0]    depth_in;

    modport source (output valid, command, pixel_x, pixel_y, depth_in, input ready);
    modport sink (input valid, command, pixel_x, pixel_y, depth_in, output ready);
endinterface
`default_nettype wire

// File: rtl/dbtw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface dbtw_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0]    depth_out;
    logic                                      was_written;
    logic                                      bad_coord;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0]    min_depth;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0]    max_depth;

    modport source (output valid, depth_out, was_written, bad_coord, min_depth, max_depth,
                    input ready);
    modport sink (input valid, depth_out, was_written, bad_coord, min_depth, max_depth,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/dbtw_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dbtw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic                          index;
    logic [dbtw_pkg::SIZE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/dbtw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer controller
// Sequences each request through capture, store read and commit, and runs
// the clearing sweep after reset and on a clear request.
// ----------------------------------------------------------------------------
module dbtw_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire dbtw_pkg::dbtw_status_t status,
    output dbtw_pkg::dbtw_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // The store read data is registered at the end of this cycle.
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = status.is_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dbtw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer datapath
// Frame size registers, address computation, depth store, depth test,
// running minimum and maximum, and the result register.
// ----------------------------------------------------------------------------
module dbtw_datapath (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire dbtw_pkg::dbtw_cmd_t                     cmd,
    output dbtw_pkg::dbtw_status_t                       status,
    input  wire logic                                    cfg_valid,
    input  wire logic                                    cfg_index,
    input  wire logic [dbtw_pkg::SIZE_W-1:0]             cfg_data,
    input  wire logic [1:0]                              command,
    input  wire logic [dbtw_pkg::COORD_W-1:0]            pixel_x,
    input  wire logic [dbtw_pkg::COORD_W-1:0]            pixel_y,
    input  wire logic signed [dbtw_pkg::DEPTH_BITS-1:0]  depth_in,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic signed [dbtw_pkg::DEPTH_BITS-1:0]       depth_out,
    output logic                                         was_written,
    output logic                                         bad_coord,
    output logic signed [dbtw_pkg::DEPTH_BITS-1:0]       min_depth,
    output logic signed [dbtw_pkg::DEPTH_BITS-1:0]       max_depth
);

    localparam int PROD_W = dbtw_pkg::COORD_W + dbtw_pkg::SIZE_W + 1;

    logic [dbtw_pkg::SIZE_W-1:0]           width_reg;
    logic [dbtw_pkg::SIZE_W-1:0]           height_reg;
    logic [dbtw_pkg::SIZE_W-1:0]           act_w;
    logic [dbtw_pkg::SIZE_W-1:0]           act_h;
    logic [PROD_W-1:0]                     addr_full;
    logic                                  bad_next;

    logic [1:0]                            cmd_reg;
    logic                                  bad_reg;
    logic [dbtw_pkg::ADDR_W-1:0]           addr_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] depth_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] rd_data_reg;
    logic [dbtw_pkg::ADDR_W-1:0]           clr_addr_reg;

    logic signed [dbtw_pkg::DEPTH_BITS-1:0] min_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] max_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] min_next;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] max_next;
    logic                                  do_write;

    logic                                  mem_we;
    logic [dbtw_pkg::ADDR_W-1:0]           mem_addr;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] mem_wdata;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] store_mem [0:dbtw_pkg::STORE_SIZE-1];

    logic                                  out_valid_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] depth_out_reg;
    logic                                  was_written_reg;
    logic                                  bad_coord_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] min_depth_reg;
    logic signed [dbtw_pkg::DEPTH_BITS-1:0] max_depth_reg;

    // Address and range check on the incoming request.
    always_comb
    begin
        act_w     = dbtw_pkg::active_size(width_reg, dbtw_pkg::WIDTH_LIMIT);
        act_h     = dbtw_pkg::active_size(height_reg, dbtw_pkg::HEIGHT_LIMIT);
        addr_full = PROD_W'(pixel_y) * PROD_W'(act_w) + PROD_W'(pixel_x);
        bad_next  = (command != dbtw_pkg::CMD_CLEAR) &&
                    ((dbtw_pkg::SIZE_W'(pixel_x) >= act_w) ||
                     (dbtw_pkg::SIZE_W'(pixel_y) >= act_h));
    end

    // Depth test and min/max update for the captured request.
    always_comb
    begin
        do_write = !bad_reg &&
                   ((cmd_reg == dbtw_pkg::CMD_WRITE) ||
                    ((cmd_reg == dbtw_pkg::CMD_TEST) && (rd_data_reg < depth_reg)));
        min_next = min_reg;
        max_next = max_reg;
        if (do_write)
        begin
            if (depth_reg < min_reg)
            begin
                min_next = depth_reg;
            end
            if (depth_reg > max_reg)
            begin
                max_next = depth_reg;
            end
        end
    end

    always_comb
    begin
        mem_we    = cmd.clear || (cmd.finish && do_write);
        mem_addr  = cmd.clear ? clr_addr_reg : addr_reg;
        mem_wdata = cmd.clear ? dbtw_pkg::DEPTH_MIN : depth_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[addr_reg];
    end

    // Captured request fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            bad_reg   <= bad_next;
            addr_reg  <= addr_full[dbtw_pkg::ADDR_W-1:0];
            depth_reg <= depth_in;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            depth_out_reg   <= (bad_reg || (cmd_reg == dbtw_pkg::CMD_CLEAR)) ? '0 : rd_data_reg;
            was_written_reg <= do_write;
            bad_coord_reg   <= bad_reg;
            min_depth_reg   <= min_next;
            max_depth_reg   <= max_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= dbtw_pkg::SIZE_RESET;
            height_reg    <= dbtw_pkg::SIZE_RESET;
            min_reg       <= dbtw_pkg::DEPTH_MAX;
            max_reg       <= dbtw_pkg::DEPTH_MIN;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == dbtw_pkg::REG_FRAME_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == dbtw_pkg::REG_FRAME_HEIGHT))
            begin
                height_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= (clr_addr_reg == dbtw_pkg::LAST_ADDR) ? '0
                                : clr_addr_reg + dbtw_pkg::ADDR_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.is_clear = (cmd_reg == dbtw_pkg::CMD_CLEAR);
        status.clr_last = (clr_addr_reg == dbtw_pkg::LAST_ADDR);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign depth_out   = depth_out_reg;
    assign was_written = was_written_reg;
    assign bad_coord   = bad_coord_reg;
    assign min_depth   = min_depth_reg;
    assign max_depth   = max_depth_reg;

endmodule
`default_nettype wire

// File: rtl/depth_buffer_test_and_write.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth buffer test-and-write
// A 512 x 512 signed Q16.16 depth store with read, write, test-and-write and
// clear requests, and a running minimum and maximum of written depths.
// ----------------------------------------------------------------------------
// Each request passes from acceptance through capture and address multiply,
// store read, and depth test and commit before its result is registered;
// the commit waits while the result register still holds an untaken result.
// The result sits in an output register, so the next request is accepted
// while the previous result still waits to be taken. After reset the block
// runs a clearing sweep over all 262144 store entries, one entry per cycle,
// and accepts no request meanwhile; a clear request returns its result and
// then runs the same sweep. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module depth_buffer_test_and_write (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dbtw_in_if.sink    item,
    dbtw_out_if.source result,
    dbtw_cfg_if.sink   cfg
);

    dbtw_pkg::dbtw_cmd_t    cmd;
    dbtw_pkg::dbtw_status_t status;
    logic                   item_ready;

    // The frame size registers take a write in any cycle.
    assign cfg.ready  = 1'b1;
    assign item.ready = item_ready;

    // The controller steps each request and the clearing sweep.
    dbtw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the store, the depth test and the result register.
    dbtw_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .command     (item.command),
        .pixel_x     (item.pixel_x),
        .pixel_y     (item.pixel_y),
        .depth_in    (item.depth_in),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .depth_out   (result.depth_out),
        .was_written (result.was_written),
        .bad_coord   (result.bad_coord),
        .min_depth   (result.min_depth),
        .max_depth   (result.max_depth)
    );

endmodule
`default_nettype wire
